### hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Round constants, initial hash values, padding constants and controller states of the hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

### hw/rtl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// Byte-serial SHA-256: block buffer in a word memory, one round per cycle.
// ----------------------------------------------------------------------------
// A byte that does not fill a block leaves the core ready for the next byte; a
// byte that fills the block is followed by 16 word loads, 64 rounds and a fold.
// End of message: one or two padded blocks with zero fill, each loaded,
// rounded and folded, then eight digest words, one per cycle as the output
// side takes them; no byte is taken while the single round unit hashes a block.
// Reset returns the initial hash and an empty block; no clearing pass.
module sha256_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [1:0]  s_tuser,   // has_byte, end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
	output logic        m_tlast    // last_word
);

	sha256_pkg::state_t state_q, state_d;

	logic [31:0] buf_mem [16];
	logic [31:0] rd_s1;
	logic [3:0]  rd_addr;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [31:0] wr_data;

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] part_q;
	logic [5:0]  fill_q;
	logic [60:0] cnt_q;
	logic [6:0]  step_q;
	logic        end_q;
	logic        fin_q;
	logic        len_q;
	logic [2:0]  out_q;

	logic        take;
	logic [5:0]  pos;
	logic [31:0] merged;
	logic [31:0] wt, s0, s1, t1, t2, e, a;
	logic [63:0] bits;

	assign take     = s_tvalid && s_tready;
	assign s_tready = (state_q == sha256_pkg::ST_IDLE);
	assign pos      = fill_q;
	assign bits     = {cnt_q, 3'b000};

	always_comb begin
		merged = part_q;
		case (pos[1:0])
			2'd0: merged[31:24] = s_tdata;
			2'd1: merged[23:16] = s_tdata;
			2'd2: merged[15:8]  = s_tdata;
			default: merged[7:0] = s_tdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[wr_addr] <= wr_data;
		end
		rd_s1 <= buf_mem[rd_addr];
	end

	always_comb begin
		wt = w_q[0];
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		e  = v_q[4];
		a  = v_q[0];
		t1 = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha256_pkg::RC[step_q[5:0]] + wt;
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = pos[5:2];
		wr_data = merged;
		rd_addr = step_q[3:0];
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (take && s_tuser[0]) begin
					wr_en = 1'b1;
					if (pos == 6'd63) begin
						state_d = sha256_pkg::ST_LOAD;
					end else if (s_tuser[1]) begin
						state_d = sha256_pkg::ST_PAD;
					end
				end else if (take && s_tuser[1]) begin
					state_d = sha256_pkg::ST_PAD;
				end
				rd_addr = 4'd0;
			end
			sha256_pkg::ST_PAD: begin
				wr_en   = 1'b1;
				wr_addr = pos[5:2];
				if (len_q) begin
					wr_data = (pos[5:2] == 4'd14) ? bits[63:32] : bits[31:0];
				end else if (fin_q) begin
					wr_data = 32'd0;
				end else begin
					wr_data = part_q;
					case (pos[1:0])
						2'd0: wr_data = {sha256_pkg::PAD_BYTE, 24'd0};
						2'd1: wr_data = {part_q[31:24], sha256_pkg::PAD_BYTE, 16'd0};
						2'd2: wr_data = {part_q[31:16], sha256_pkg::PAD_BYTE, 8'd0};
						default: wr_data = {part_q[31:8], sha256_pkg::PAD_BYTE};
					endcase
				end
				if (pos[5:2] == 4'd15) begin
					state_d = sha256_pkg::ST_LOAD;
				end else if (!len_q && fin_q && pos == 6'd52) begin
					state_d = sha256_pkg::ST_PAD;
				end
				rd_addr = 4'd0;
			end
			sha256_pkg::ST_LOAD: begin
				if (step_q == 7'd16) begin
					state_d = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_ROUND: begin
				if (step_q == 7'd63) begin
					state_d = sha256_pkg::ST_FOLD;
				end
			end
			sha256_pkg::ST_FOLD: begin
				if (len_q) begin
					state_d = sha256_pkg::ST_EMIT;
				end else if (fin_q || end_q) begin
					state_d = sha256_pkg::ST_PAD;
				end else begin
					state_d = sha256_pkg::ST_IDLE;
				end
			end
			sha256_pkg::ST_EMIT: begin
				if (m_tready && out_q == 3'd7) begin
					state_d = sha256_pkg::ST_IDLE;
				end
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
			step_q  <= '0;
			end_q   <= 1'b0;
			fin_q   <= 1'b0;
			len_q   <= 1'b0;
			out_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha256_pkg::IV[i];
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					step_q <= '0;
					if (take) begin
						end_q <= s_tuser[1];
						fin_q <= 1'b0;
						len_q <= 1'b0;
						if (s_tuser[0]) begin
							fill_q <= pos + 6'd1;
							cnt_q  <= cnt_q + 61'd1;
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					step_q <= '0;
					if (len_q) begin
						fill_q <= pos + 6'd4;
					end else if (fin_q) begin
						fill_q <= pos + 6'd4;
						if (pos == 6'd52) begin
							len_q <= 1'b1;
						end
					end else begin
						fin_q  <= 1'b1;
						fill_q <= {pos[5:2], 2'b00} + 6'd4;
						if (pos >= sha256_pkg::LEN_POS) begin
							len_q <= 1'b0;
						end else if (pos[5:2] == 4'd13) begin
							len_q <= 1'b1;
						end
					end
				end
				sha256_pkg::ST_LOAD: begin
					step_q <= step_q + 7'd1;
					if (step_q != 7'd0) begin
						w_q[step_q[3:0] - 4'd1] <= rd_s1;
					end
					if (step_q == 7'd16) begin
						step_q <= '0;
						for (int i = 0; i < 8; i++) begin
							v_q[i] <= h_q[i];
						end
					end
				end
				sha256_pkg::ST_ROUND: begin
					step_q <= step_q + 7'd1;
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i + 1];
					end
					w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
				end
				sha256_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					fill_q <= '0;
					out_q  <= '0;
				end
				sha256_pkg::ST_EMIT: begin
					if (m_tready) begin
						out_q <= out_q + 3'd1;
						if (out_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= sha256_pkg::IV[i];
							end
							fill_q <= '0;
							cnt_q  <= '0;
							end_q  <= 1'b0;
							fin_q  <= 1'b0;
							len_q  <= 1'b0;
						end
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

	// hold the partial word of the block for byte merging
	always_ff @(posedge clk) begin
		if (take && s_tuser[0]) begin
			part_q <= (pos[1:0] == 2'd3) ? 32'd0 : merged;
		end else if (state_q == sha256_pkg::ST_PAD) begin
			part_q <= 32'd0;
		end
	end

	assign m_tvalid = (state_q == sha256_pkg::ST_EMIT);
	assign m_tdata  = {5'd0, out_q, h_q[out_q]};
	assign m_tlast  = (out_q == 3'd7);

endmodule
